@@ rtl/kms_pkg.sv @@
// Shared types, constants and the key remapping table of the keypad matrix scanner.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package kms_pkg;

  localparam int unsigned ColWidth      = 4;
  localparam int unsigned RowWidth      = 4;
  localparam int unsigned CodeWidth     = 5;
  localparam int unsigned CfgWidth      = 16;
  localparam int unsigned DefCountWidth = 16;
  localparam int unsigned ApbAddrWidth  = 3;
  localparam int unsigned ApbDataWidth  = 32;

  localparam logic [CfgWidth-1:0] DebounceReset = 16'd10;
  localparam logic [CfgWidth-1:0] BeepReset     = 16'd50;

  // Register index, taken from the word address bit of the APB port.
  typedef enum logic {
    RegDebounce = 1'b0,
    RegBeep     = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    PhScan     = 2'd0,
    PhDebounce = 2'd1,
    PhRelease  = 2'd2
  } phase_e;

  // Raw key (row * 4 + column) to the printed key code.
  function automatic logic [CodeWidth-1:0] key_map(input logic [3:0] raw);
    logic [CodeWidth-1:0] code;
    unique case (raw)
      4'd0:    code = 5'd1;
      4'd1:    code = 5'd2;
      4'd2:    code = 5'd3;
      4'd3:    code = 5'd13;
      4'd4:    code = 5'd4;
      4'd5:    code = 5'd5;
      4'd6:    code = 5'd6;
      4'd7:    code = 5'd14;
      4'd8:    code = 5'd7;
      4'd9:    code = 5'd8;
      4'd10:   code = 5'd9;
      4'd11:   code = 5'd15;
      4'd12:   code = 5'd10;
      4'd13:   code = 5'd0;
      4'd14:   code = 5'd12;
      default: code = 5'd16;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/kms_in_if.sv @@
// Input channel of the keypad matrix scanner: one word of sampled column levels.
// Depends on kms_pkg.
`timescale 1ns / 1ps

interface kms_in_if;
  logic                         valid;
  logic                         ready;
  logic [kms_pkg::ColWidth-1:0] column_levels;

  modport source (output valid, output column_levels, input ready);
  modport sink   (input valid, input column_levels, output ready);
endinterface

@@ rtl/kms_out_if.sv @@
// Output channel of the keypad matrix scanner: row drive, key report and buzzer.
// Depends on kms_pkg.
`timescale 1ns / 1ps

interface kms_out_if;
  logic                          valid;
  logic                          ready;
  logic [kms_pkg::RowWidth-1:0]  row_drive;
  logic                          key_valid;
  logic [kms_pkg::CodeWidth-1:0] key_code;
  logic                          buzzer_on;

  modport source (output valid, output row_drive, output key_valid, output key_code,
                  output buzzer_on, input ready);
  modport sink   (input valid, input row_drive, input key_valid, input key_code,
                  input buzzer_on, output ready);
endinterface

@@ rtl/keypad_matrix_scanner_unit.sv @@
// Keypad matrix scanner top level: scan state machine, counters and APB registers.
// Depends on kms_pkg, kms_in_if and kms_out_if.
`timescale 1ns / 1ps

// Each input word is one scan tick: the four active-low column levels sampled under
// the row reported in that tick's output word. The block takes one word per clock
// cycle and delivers its output word from a result register in the next cycle; it
// accepts a new word whenever that register is empty or being read in the same
// cycle, so one tick per cycle is sustained. The scan state, the debounce counter and
// the buzzer counter update in the cycle a word is accepted. Counters are COUNT_WIDTH
// bits wide and register values above that range saturate. Configuration goes through
// an APB port: debounce_ticks at byte 0, beep_ticks at byte 4; write only when idle.
module keypad_matrix_scanner_unit #(
  parameter int unsigned COUNT_WIDTH = kms_pkg::DefCountWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [kms_pkg::ApbAddrWidth-1:0] paddr,
  input  logic [kms_pkg::ApbDataWidth-1:0] pwdata,
  output logic [kms_pkg::ApbDataWidth-1:0] prdata,
  output logic                             pready,
  kms_in_if.sink                           in_i,
  kms_out_if.source                        out_o
);

  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  // Configuration registers
  logic [kms_pkg::CfgWidth-1:0] debounce_ticks_q, beep_ticks_q;
  kms_pkg::reg_idx_e            reg_idx;
  logic                         cfg_wr;

  assign reg_idx = kms_pkg::reg_idx_e'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ticks_q <= kms_pkg::DebounceReset;
      beep_ticks_q     <= kms_pkg::BeepReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        kms_pkg::RegDebounce: debounce_ticks_q <= pwdata[kms_pkg::CfgWidth-1:0];
        kms_pkg::RegBeep:     beep_ticks_q     <= pwdata[kms_pkg::CfgWidth-1:0];
        default:              ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      kms_pkg::RegDebounce: prdata = kms_pkg::ApbDataWidth'(debounce_ticks_q);
      kms_pkg::RegBeep:     prdata = kms_pkg::ApbDataWidth'(beep_ticks_q);
      default:              prdata = '0;
    endcase
  end

  // Register values clipped to the counter range
  logic [31:0]            deb_ext, beep_ext;
  logic [COUNT_WIDTH-1:0] deb_load, beep_load;

  assign deb_ext   = 32'(debounce_ticks_q);
  assign beep_ext  = 32'(beep_ticks_q);
  assign deb_load  = (deb_ext > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                          : deb_ext[COUNT_WIDTH-1:0];
  assign beep_load = (beep_ext > CountMax) ? CountMax[COUNT_WIDTH-1:0]
                                           : beep_ext[COUNT_WIDTH-1:0];

  // Handshake
  logic out_valid_q, in_fire;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;

  // Scan state
  kms_pkg::phase_e        phase_q, phase_d;
  logic [1:0]             row_q, row_d;
  logic [1:0]             held_q, held_d;
  logic [COUNT_WIDTH-1:0] deb_cnt_q, deb_cnt_d;
  logic [COUNT_WIDTH-1:0] beep_q, beep_d;

  logic [kms_pkg::ColWidth-1:0] cols;
  logic                         any_low, low_found, held_high, deb_wait;
  logic [1:0]                   low_col;

  assign cols      = in_i.column_levels;
  assign any_low   = (cols != '1);
  assign held_high = cols[held_q];
  assign deb_wait  = (deb_cnt_q > COUNT_WIDTH'(1));

  // Lowest column that reads low
  always_comb begin
    low_found = 1'b1;
    low_col   = 2'd0;
    priority if (!cols[0]) low_col = 2'd0;
    else if (!cols[1])     low_col = 2'd1;
    else if (!cols[2])     low_col = 2'd2;
    else if (!cols[3])     low_col = 2'd3;
    else                   low_found = 1'b0;
  end

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      kms_pkg::PhDebounce: begin
        if (!deb_wait) phase_d = low_found ? kms_pkg::PhRelease : kms_pkg::PhScan;
      end
      kms_pkg::PhRelease: begin
        if (held_high) phase_d = kms_pkg::PhScan;
      end
      default: begin
        phase_d = any_low ? kms_pkg::PhDebounce : kms_pkg::PhScan;
      end
    endcase
  end

  // Counters, row, held column and the key report
  logic                          key_now;
  logic [kms_pkg::CodeWidth-1:0] code_now;

  always_comb begin
    row_d     = row_q;
    held_d    = held_q;
    deb_cnt_d = deb_cnt_q;
    key_now   = 1'b0;
    beep_d    = (beep_q != '0) ? beep_q - COUNT_WIDTH'(1) : beep_q;
    unique case (phase_q)
      kms_pkg::PhDebounce: begin
        if (deb_wait) begin
          deb_cnt_d = deb_cnt_q - COUNT_WIDTH'(1);
        end else begin
          deb_cnt_d = '0;
          if (low_found) held_d = low_col;
          else           row_d  = row_q + 2'd1;
        end
      end
      kms_pkg::PhRelease: begin
        if (held_high) begin
          key_now = 1'b1;
          beep_d  = beep_load;
          row_d   = row_q + 2'd1;
        end
      end
      default: begin
        if (any_low) deb_cnt_d = deb_load;
        else         row_d     = row_q + 2'd1;
      end
    endcase
    code_now = key_now ? kms_pkg::key_map({row_q, held_q}) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= kms_pkg::PhScan;
      row_q     <= 2'd0;
      held_q    <= 2'd0;
      deb_cnt_q <= '0;
      beep_q    <= '0;
    end else if (in_fire) begin
      phase_q   <= phase_d;
      row_q     <= row_d;
      held_q    <= held_d;
      deb_cnt_q <= deb_cnt_d;
      beep_q    <= beep_d;
    end
  end

  // Result register
  logic [kms_pkg::RowWidth-1:0]  row_drive_q;
  logic                          key_valid_q;
  logic [kms_pkg::CodeWidth-1:0] key_code_q;
  logic                          buzzer_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      row_drive_q <= ~(kms_pkg::RowWidth'(1) << row_q);
      key_valid_q <= key_now;
      key_code_q  <= code_now;
      buzzer_q    <= (beep_q != '0);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.row_drive = row_drive_q;
  assign out_o.key_valid = key_valid_q;
  assign out_o.key_code  = key_code_q;
  assign out_o.buzzer_on = buzzer_q;

  // A key is only reported from the release phase.
  a_key_from_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && key_now |-> phase_q == kms_pkg::PhRelease)
    else $error("key reported outside the release phase");

  // A reported key reloads the buzzer counter with the clipped beep count.
  a_beep_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && key_now |=> beep_q == $past(beep_load))
    else $error("buzzer counter not reloaded on a key");

  // Release is entered only once the debounce count has run out.
  a_release_after_debounce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && phase_q != kms_pkg::PhRelease && phase_d == kms_pkg::PhRelease
    |-> phase_q == kms_pkg::PhDebounce && !deb_wait)
    else $error("release entered before debounce finished");

  // Exactly one row is driven low in every delivered word, and codes only go with keys.
  a_out_word_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot(~row_drive_q) && (key_valid_q || key_code_q == '0))
    else $error("malformed output word");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for keypad_matrix_scanner_unit: random scan ticks, random stalls.
// Depends on kms_pkg, kms_in_if, kms_out_if and the scanner top level.
// Every output word is checked against a cycle-free model of the scan state machine.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned IdleLimit = 2000;

  // Printed key code for each raw key, indexed by row * 4 + column.
  localparam logic [kms_pkg::CodeWidth-1:0] KeyCodeTable [16] = '{
    5'd1, 5'd2, 5'd3, 5'd13, 5'd4, 5'd5, 5'd6, 5'd14,
    5'd7, 5'd8, 5'd9, 5'd15, 5'd10, 5'd0, 5'd12, 5'd16
  };

  typedef struct packed {
    logic [kms_pkg::RowWidth-1:0]  row_drive;
    logic                          key_valid;
    logic [kms_pkg::CodeWidth-1:0] key_code;
    logic                          buzzer_on;
  } scan_word_t;

  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyCoin,
    ReadyToggle,
    ReadyBursty
  } ready_mode_e;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [kms_pkg::ApbAddrWidth-1:0] paddr;
  logic [kms_pkg::ApbDataWidth-1:0] pwdata;
  logic [kms_pkg::ApbDataWidth-1:0] prdata;
  logic pready;

  kms_in_if  in_ch ();
  kms_out_if out_ch ();

  keypad_matrix_scanner_unit u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  // Column samples waiting to be sent, and the output words they must produce.
  logic [kms_pkg::ColWidth-1:0] column_ticks_q[$];
  scan_word_t                   expected_words_q[$];

  // Scanner model state and its copy of the registers.
  kms_pkg::phase_e              scan_phase;
  logic [1:0]                   scan_row;
  logic [1:0]                   held_col;
  logic [kms_pkg::CfgWidth-1:0] debounce_left;
  logic [kms_pkg::CfgWidth-1:0] beep_left;
  logic [kms_pkg::CfgWidth-1:0] debounce_cfg;
  logic [kms_pkg::CfgWidth-1:0] beep_cfg;

  int unsigned mismatches;
  int unsigned words_checked;
  int unsigned keys_reported;
  int unsigned reg_writes;
  int unsigned ticks_queued;
  int unsigned idle_cycles;
  logic [16:0] codes_seen;

  int unsigned gap_left;
  int unsigned burst_left;
  ready_mode_e ready_mode;
  int unsigned mode_left;
  int unsigned stall_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Advances the scanner model by one tick and queues the word it must emit.
  task automatic scan_tick(input logic [kms_pkg::ColWidth-1:0] cols);
    scan_word_t w;
    logic       found;
    logic [1:0] low_col;
    w.row_drive = ~(4'b0001 << scan_row);
    w.key_valid = 1'b0;
    w.key_code  = '0;
    w.buzzer_on = (beep_left != 0);
    found       = 1'b0;
    low_col     = 2'd0;
    if (beep_left != 0) beep_left = beep_left - 16'd1;
    case (scan_phase)
      kms_pkg::PhDebounce: begin
        if (debounce_left > 1) begin
          debounce_left = debounce_left - 16'd1;
        end else begin
          debounce_left = '0;
          for (int c = 3; c >= 0; c--) begin
            if (!cols[c]) begin
              found   = 1'b1;
              low_col = 2'(c);
            end
          end
          if (found) begin
            held_col   = low_col;
            scan_phase = kms_pkg::PhRelease;
          end else begin
            scan_phase = kms_pkg::PhScan;
            scan_row   = scan_row + 2'd1;
          end
        end
      end
      kms_pkg::PhRelease: begin
        if (cols[held_col]) begin
          w.key_valid = 1'b1;
          w.key_code  = KeyCodeTable[{scan_row, held_col}];
          beep_left   = beep_cfg;
          scan_phase  = kms_pkg::PhScan;
          scan_row    = scan_row + 2'd1;
        end
      end
      default: begin
        scan_phase = kms_pkg::PhScan;
        if (cols != 4'hF) begin
          debounce_left = debounce_cfg;
          scan_phase    = kms_pkg::PhDebounce;
        end else begin
          scan_row = scan_row + 2'd1;
        end
      end
    endcase
    expected_words_q.push_back(w);
  endtask

  // Sender: bursts of random length separated by random gaps, some of them empty.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid         <= 1'b0;
      in_ch.column_levels <= 4'hF;
      gap_left            <= 0;
      burst_left          <= 1;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        scan_tick(in_ch.column_levels);
        void'(column_ticks_q.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // Word still pending; hold it.
      end else if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (column_ticks_q.size() != 0) begin
        in_ch.valid         <= 1'b1;
        in_ch.column_levels <= column_ticks_q[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 60);
          gap_left   <= ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  task automatic check_word();
    scan_word_t got;
    scan_word_t want;
    got = '{out_ch.row_drive, out_ch.key_valid, out_ch.key_code, out_ch.buzzer_on};
    if (expected_words_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: word with nothing expected: row=%b key_valid=%0d key=%0d buzzer=%0d",
                 $time, got.row_drive, got.key_valid, got.key_code, got.buzzer_on);
    end else begin
      want = expected_words_q.pop_front();
      words_checked++;
      if (got.row_drive !== want.row_drive || got.key_valid !== want.key_valid ||
          got.key_code !== want.key_code || got.buzzer_on !== want.buzzer_on) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: word %0d: expected row=%b key_valid=%0d key=%0d buzzer=%0d,",
                    " got row=%b key_valid=%0d key=%0d buzzer=%0d"},
                   $time, words_checked, want.row_drive, want.key_valid, want.key_code,
                   want.buzzer_on, got.row_drive, got.key_valid, got.key_code, got.buzzer_on);
      end
      if (want.key_valid) begin
        keys_reported++;
        codes_seen[want.key_code] = 1'b1;
      end
    end
  endtask

  // Receiver: switches between stall patterns every so often.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      ready_mode   <= ReadyAlways;
      mode_left    <= 0;
      stall_left   <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) check_word();
      if (mode_left == 0) begin
        ready_mode <= ready_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(16, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        ReadyAlways: out_ch.ready <= 1'b1;
        ReadyCoin:   out_ch.ready <= 1'($urandom_range(0, 1));
        ReadyToggle: out_ch.ready <= ~out_ch.ready;
        default: begin
          if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            out_ch.ready <= 1'b0;
          end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input kms_pkg::reg_idx_e idx, input logic [15:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == kms_pkg::RegDebounce) debounce_cfg = value;
    else beep_cfg = value;
    reg_writes++;
  endtask

  // Waits until every queued tick has gone in and every word has come out.
  task automatic drain();
    while (column_ticks_q.size() != 0 || expected_words_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic push_tick(input logic [3:0] cols);
    column_ticks_q.push_back(cols);
    ticks_queued++;
  endtask

  function automatic logic [3:0] any_pressed();
    return 4'($urandom_range(0, 14));
  endfunction

  // A full press: detection, debounce wait, confirmation, hold and release (unless broken).
  // With bounce the samples during the wait are arbitrary.
  task automatic push_keystroke(input bit bounce, input bit broken);
    logic [3:0]  first;
    logic [3:0]  confirm;
    logic [3:0]  v;
    int unsigned waits;
    int unsigned c;
    first = any_pressed();
    waits = (debounce_cfg <= 1) ? 0 : debounce_cfg - 1;
    push_tick(first);
    for (int unsigned i = 0; i < waits; i++) push_tick(bounce ? 4'($urandom) : first);
    if (broken) begin
      // Released before the press was confirmed.
      push_tick(4'hF);
    end else begin
      confirm = bounce ? any_pressed() : first;
      c = 0;
      while (confirm[c]) c++;
      push_tick(confirm);
      repeat ($urandom_range(0, 3)) begin
        v    = 4'($urandom);
        v[c] = 1'b0;
        push_tick(v);
      end
      v    = ($urandom_range(0, 9) < 7) ? 4'hF : 4'($urandom);
      v[c] = 1'b1;
      push_tick(v);
    end
    repeat ($urandom_range(0, 5)) push_tick(4'hF);
  endtask

  task automatic random_phase(input int unsigned budget);
    int unsigned start;
    int unsigned pick;
    start = ticks_queued;
    while (ticks_queued - start < budget) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) push_keystroke(1'b0, 1'b0);
      else if (pick < 8) push_keystroke(1'b1, 1'b0);
      else if (pick == 8) push_keystroke(1'b1, 1'b1);
      else repeat ($urandom_range(1, 6)) push_tick(4'($urandom));
    end
  endtask

  initial begin
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    scan_phase          = kms_pkg::PhScan;
    scan_row            = 2'd0;
    held_col            = 2'd0;
    debounce_left       = '0;
    beep_left           = '0;
    debounce_cfg        = kms_pkg::DebounceReset;
    beep_cfg            = kms_pkg::BeepReset;
    mismatches          = 0;
    words_checked       = 0;
    keys_reported       = 0;
    reg_writes          = 0;
    ticks_queued        = 0;
    codes_seen          = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values of both registers.
    repeat (4) push_keystroke(1'b0, 1'b0);
    drain();

    // Directed: zero debounce, silent buzzer, all-low columns, lowest column wins,
    // a press gone by confirmation, and each single column.
    write_reg(kms_pkg::RegDebounce, 16'd0);
    write_reg(kms_pkg::RegBeep, 16'd0);
    push_tick(4'hF); push_tick(4'hF); push_tick(4'hF);
    push_tick(4'hE); push_tick(4'hE); push_tick(4'hE); push_tick(4'hF);
    push_tick(4'h0); push_tick(4'h0); push_tick(4'h1);
    push_tick(4'h7); push_tick(4'hF);
    push_tick(4'h7); push_tick(4'h7); push_tick(4'hF);
    push_tick(4'hB); push_tick(4'hB); push_tick(4'h4);
    push_tick(4'hD); push_tick(4'hD); push_tick(4'h2);
    drain();

    write_reg(kms_pkg::RegDebounce, 16'd1);
    write_reg(kms_pkg::RegBeep, 16'd1);
    random_phase(300);
    drain();
    write_reg(kms_pkg::RegDebounce, 16'd2);
    write_reg(kms_pkg::RegBeep, 16'd0);
    random_phase(300);
    drain();
    write_reg(kms_pkg::RegDebounce, 16'd0);
    write_reg(kms_pkg::RegBeep, 16'd7);
    random_phase(300);
    drain();
    repeat (4) begin
      write_reg(kms_pkg::RegDebounce, 16'($urandom_range(1, 8)));
      write_reg(kms_pkg::RegBeep, 16'($urandom_range(0, 40)));
      random_phase(270);
      drain();
    end

    // Largest counts: the buzzer stays on to the end, and the last press is still
    // waiting out its debounce count when the run stops.
    write_reg(kms_pkg::RegDebounce, 16'd3);
    write_reg(kms_pkg::RegBeep, 16'hFFFF);
    push_keystroke(1'b0, 1'b0);
    push_keystroke(1'b0, 1'b0);
    drain();
    write_reg(kms_pkg::RegDebounce, 16'hFFFF);
    push_tick(any_pressed());
    repeat (20) push_tick(4'($urandom));
    drain();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d scan words over %0d register writes; %0d keys reported.",
             words_checked, reg_writes, keys_reported);
    $display("Key codes seen (bit per code 16..0): %b", codes_seen);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatching words.", mismatches);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/kms_pkg.sv
rtl/kms_in_if.sv
rtl/kms_out_if.sv
rtl/keypad_matrix_scanner_unit.sv
tb/tb.sv
